### rtl/core/pmid_pkg.sv
package pmid_pkg;

    localparam int COMP_W  = 21;
    localparam int D_W     = 24;
    localparam int SQ_W    = 48;
    localparam int ROOT_W  = 24;
    localparam int IDX_W   = 5;
    localparam int NUM_IMG = 27;

    // Candidate travelling along the row of image cells.
    typedef struct packed {
        logic                   valid;
        logic signed [D_W-1:0]  base_x;
        logic signed [D_W-1:0]  base_y;
        logic signed [D_W-1:0]  base_z;
        logic [SQ_W-1:0]        best_sq;
        logic signed [D_W-1:0]  best_x;
        logic signed [D_W-1:0]  best_y;
        logic signed [D_W-1:0]  best_z;
        logic [IDX_W-1:0]       best_idx;
    } t_cand;

    // Partial square root travelling along the root stages.
    typedef struct packed {
        logic                   valid;
        logic signed [D_W-1:0]  dx;
        logic signed [D_W-1:0]  dy;
        logic signed [D_W-1:0]  dz;
        logic [IDX_W-1:0]       idx;
        logic [SQ_W-1:0]        rem;
        logic [ROOT_W-1:0]      root;
    } t_root;

    // Scales a lattice component by an offset of -1, 0 or +1.
    function automatic logic signed [D_W-1:0] off_mul(input int off,
                                                     input logic [COMP_W-1:0] v);
        logic signed [D_W-1:0] e;
        e = D_W'(signed'(v));
        if (off > 0) begin
            return e;
        end else if (off < 0) begin
            return -e;
        end
        return '0;
    endfunction

endpackage

### rtl/core/periodic_min_image_distance_core.sv
// Minimum-image displacement between two points of a periodic 3-D lattice.
// Configuration: write i_cfg_wr_en with i_cfg_index (0..2 lattice rows A, B, C,
// 3 inverse mapping) and i_cfg_data, only while no transaction is in flight.
// Input: a transaction is taken on a rising edge with start high and busy low.
// busy is never raised, so one point pair may be issued every cycle.
// Output: o_valid marks one cycle carrying the shortest displacement, its
// length and the chosen image index; the receiver cannot stall the block.
// From start to o_valid a pair passes four front-end stages (wrap,
// difference, lattice product, rounding), 27 image cells that each test one
// neighbour image and hand the best so far on, then 24 square-root stages
// that each settle one bit of the length. Throughput is one pair per cycle.
// Reset clears the configuration registers and empties the pipeline.
module periodic_min_image_distance_core (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_wr_en,
    input  logic [1:0]         i_cfg_index,
    input  logic [62:0]        i_cfg_data,
    input  logic               start,
    output logic               busy,
    input  logic signed [23:0] i_first_frac_x,
    input  logic signed [23:0] i_first_frac_y,
    input  logic signed [23:0] i_first_frac_z,
    input  logic signed [23:0] i_second_frac_x,
    input  logic signed [23:0] i_second_frac_y,
    input  logic signed [23:0] i_second_frac_z,
    output logic               o_valid,
    output logic signed [23:0] o_delta_x,
    output logic signed [23:0] o_delta_y,
    output logic signed [23:0] o_delta_z,
    output logic [23:0]        o_separation,
    output logic [4:0]         o_image_index
);

    localparam logic [1:0] REG_ROW_A = 2'd0;
    localparam logic [1:0] REG_ROW_B = 2'd1;
    localparam logic [1:0] REG_ROW_C = 2'd2;
    localparam logic [1:0] REG_MINV  = 2'd3;

    logic [62:0] r_row_a, r_row_b, r_row_c;
    logic [44:0] r_minv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_a <= '0;
            r_row_b <= '0;
            r_row_c <= '0;
            r_minv  <= '0;
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_index)
                REG_ROW_A: r_row_a <= i_cfg_data;
                REG_ROW_B: r_row_b <= i_cfg_data;
                REG_ROW_C: r_row_c <= i_cfg_data;
                REG_MINV:  r_minv  <= i_cfg_data[44:0];
                default:   r_minv  <= r_minv;
            endcase
        end
    end

    assign busy = 1'b0;

    // Wrap modulo one: only the low 16 bits of the reduced fraction matter.
    logic [15:0] m [3][3];
    logic [15:0] f1 [3];
    logic [15:0] f2 [3];
    logic [15:0] n_g1 [3];
    logic [15:0] n_g2 [3];
    logic [15:0] r_g1 [3];
    logic [15:0] r_g2 [3];
    logic        r_v1, r_v2, r_v3, r_v4;

    assign f1[0] = i_first_frac_x[15:0];
    assign f1[1] = i_first_frac_y[15:0];
    assign f1[2] = i_first_frac_z[15:0];
    assign f2[0] = i_second_frac_x[15:0];
    assign f2[1] = i_second_frac_y[15:0];
    assign f2[2] = i_second_frac_z[15:0];

    always_comb begin
        for (int r = 0; r < 3; r++) begin
            for (int c = 0; c < 3; c++) begin
                m[r][c] = 16'(signed'(r_minv[5*(3*r+c) +: 5]));
            end
        end
        for (int j = 0; j < 3; j++) begin
            n_g1[j] = 16'(f1[0] * m[0][j] + f1[1] * m[1][j] + f1[2] * m[2][j]);
            n_g2[j] = 16'(f2[0] * m[0][j] + f2[1] * m[1][j] + f2[2] * m[2][j]);
        end
    end

    always_ff @(posedge i_clk) begin
        r_g1 <= n_g1;
        r_g2 <= n_g2;
    end

    // The Cartesian difference is linear, so the fractions are subtracted first.
    logic signed [16:0] r_dg [3];
    logic signed [20:0] lat [3][3];
    logic signed [38:0] n_pre [3];
    logic signed [38:0] r_pre [3];
    logic signed [38:0] rnd [3];
    logic signed [23:0] r_base [3];

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < 3; i++) begin
            r_dg[i] <= signed'({1'b0, r_g2[i]}) - signed'({1'b0, r_g1[i]});
        end
    end

    always_comb begin
        for (int j = 0; j < 3; j++) begin
            lat[0][j] = signed'(r_row_a[21*j +: 21]);
            lat[1][j] = signed'(r_row_b[21*j +: 21]);
            lat[2][j] = signed'(r_row_c[21*j +: 21]);
        end
        for (int j = 0; j < 3; j++) begin
            n_pre[j] = 39'(r_dg[0]) * 39'(lat[0][j]) + 39'(r_dg[1]) * 39'(lat[1][j])
                     + 39'(r_dg[2]) * 39'(lat[2][j]);
            // Half up, then floor: an arithmetic shift after adding one half.
            rnd[j] = r_pre[j] + 39'sd32768;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pre <= n_pre;
        for (int j = 0; j < 3; j++) begin
            r_base[j] <= 24'(rnd[j] >>> 16);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else begin
            r_v1 <= start && !busy;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            r_v4 <= r_v3;
        end
    end

    pmid_pkg::t_cand cand [pmid_pkg::NUM_IMG+1];

    always_comb begin
        cand[0]          = '0;
        cand[0].valid    = r_v4;
        cand[0].base_x   = r_base[0];
        cand[0].base_y   = r_base[1];
        cand[0].base_z   = r_base[2];
        cand[0].best_sq  = '1;
    end

    for (genvar k = 0; k < pmid_pkg::NUM_IMG; k++) begin : g_cell
        pmid_cell #(.K(k)) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_row_a (r_row_a),
            .i_row_b (r_row_b),
            .i_row_c (r_row_c),
            .i_cand  (cand[k]),
            .o_cand  (cand[k+1])
        );
    end

    pmid_pkg::t_root root [pmid_pkg::ROOT_W+1];
    pmid_pkg::t_cand last;

    assign last = cand[pmid_pkg::NUM_IMG];

    always_comb begin
        root[0].valid = last.valid;
        root[0].dx    = last.best_x;
        root[0].dy    = last.best_y;
        root[0].dz    = last.best_z;
        root[0].idx   = last.best_idx;
        root[0].rem   = last.best_sq;
        root[0].root  = '0;
    end

    // Root bits are settled from the most significant one down.
    for (genvar s = 0; s < pmid_pkg::ROOT_W; s++) begin : g_root
        pmid_sqrt_step #(.B(pmid_pkg::ROOT_W - 1 - s)) u_step (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_root  (root[s]),
            .o_root  (root[s+1])
        );
    end

    assign o_valid       = root[pmid_pkg::ROOT_W].valid;
    assign o_delta_x     = root[pmid_pkg::ROOT_W].dx;
    assign o_delta_y     = root[pmid_pkg::ROOT_W].dy;
    assign o_delta_z     = root[pmid_pkg::ROOT_W].dz;
    assign o_separation  = root[pmid_pkg::ROOT_W].root;
    assign o_image_index = root[pmid_pkg::ROOT_W].idx;

endmodule

### rtl/core/pmid_cell.sv
module pmid_cell #(
    parameter int K = 0
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic [62:0]            i_row_a,
    input  logic [62:0]            i_row_b,
    input  logic [62:0]            i_row_c,
    input  pmid_pkg::t_cand        i_cand,
    output pmid_pkg::t_cand        o_cand
);

    localparam int OA = K / 9 - 1;
    localparam int OB = (K / 3) % 3 - 1;
    localparam int OC = K % 3 - 1;

    logic signed [pmid_pkg::D_W-1:0]  img_x, img_y, img_z;
    logic signed [pmid_pkg::D_W-1:0]  d_x, d_y, d_z;
    logic signed [pmid_pkg::SQ_W-1:0] sq_x, sq_y, sq_z;
    logic [pmid_pkg::SQ_W-1:0]        sq;
    pmid_pkg::t_cand                  n_cand;
    pmid_pkg::t_cand                  r_cand;

    assign img_x = pmid_pkg::off_mul(OA, i_row_a[20:0]) + pmid_pkg::off_mul(OB, i_row_b[20:0])
                 + pmid_pkg::off_mul(OC, i_row_c[20:0]);
    assign img_y = pmid_pkg::off_mul(OA, i_row_a[41:21]) + pmid_pkg::off_mul(OB, i_row_b[41:21])
                 + pmid_pkg::off_mul(OC, i_row_c[41:21]);
    assign img_z = pmid_pkg::off_mul(OA, i_row_a[62:42]) + pmid_pkg::off_mul(OB, i_row_b[62:42])
                 + pmid_pkg::off_mul(OC, i_row_c[62:42]);

    // The image offset has no fraction bits, so it adds after rounding.
    assign d_x = i_cand.base_x + img_x;
    assign d_y = i_cand.base_y + img_y;
    assign d_z = i_cand.base_z + img_z;

    assign sq_x = pmid_pkg::SQ_W'(d_x) * pmid_pkg::SQ_W'(d_x);
    assign sq_y = pmid_pkg::SQ_W'(d_y) * pmid_pkg::SQ_W'(d_y);
    assign sq_z = pmid_pkg::SQ_W'(d_z) * pmid_pkg::SQ_W'(d_z);
    assign sq   = pmid_pkg::SQ_W'(sq_x + sq_y + sq_z);

    always_comb begin
        n_cand = i_cand;
        // Strictly shorter only, so the first minimum is kept.
        if (sq < i_cand.best_sq) begin
            n_cand.best_sq  = sq;
            n_cand.best_x   = d_x;
            n_cand.best_y   = d_y;
            n_cand.best_z   = d_z;
            n_cand.best_idx = pmid_pkg::IDX_W'(K);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cand <= '0;
        end else begin
            r_cand <= n_cand;
        end
    end

    assign o_cand = r_cand;

endmodule

### rtl/core/pmid_sqrt_step.sv
module pmid_sqrt_step #(
    parameter int B = 0
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  pmid_pkg::t_root  i_root,
    output pmid_pkg::t_root  o_root
);

    logic [pmid_pkg::SQ_W:0] trial;
    pmid_pkg::t_root         n_root;
    pmid_pkg::t_root         r_root;

    // (q + 2^B)^2 - q^2, with q holding only bits above B.
    assign trial = ((pmid_pkg::SQ_W+1)'(i_root.root) << (B + 1))
                 + ((pmid_pkg::SQ_W+1)'(1) << (2 * B));

    always_comb begin
        n_root = i_root;
        if ({1'b0, i_root.rem} >= trial) begin
            n_root.rem  = pmid_pkg::SQ_W'({1'b0, i_root.rem} - trial);
            n_root.root = i_root.root | (pmid_pkg::ROOT_W'(1) << B);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_root <= '0;
        end else begin
            r_root <= n_root;
        end
    end

    assign o_root = r_root;

endmodule
